>>> hw/rtl/lhc_pkg.sv
// Package: widths, payload types and codes shared by the letterbox hold check block.
`default_nettype none
package lhc_pkg;

    localparam int DIM_BITS      = 16;
    localparam int FRACTION_BITS = 16;
    localparam int ORIGIN_BITS   = 16;
    localparam int MINF_W        = FRACTION_BITS + 1;
    localparam int TOL_W         = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = MINF_W;
    localparam int FRAC_PROD_W   = DIM_BITS + MINF_W;
    localparam int PROD_W        = 2 * DIM_BITS;
    localparam int TOL_PROD_W    = TOL_W + DIM_BITS;

    typedef logic [DIM_BITS-1:0]    dim_t;
    typedef logic [MINF_W-1:0]      minf_t;
    typedef logic [TOL_W-1:0]       tol_t;
    typedef logic [FRAC_PROD_W-1:0] frac_prod_t;
    typedef logic [PROD_W-1:0]      prod_t;
    typedef logic [TOL_PROD_W-1:0]  tol_prod_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_FRACTION    = 1'b0,
        REG_RATIO_TOLERANCE = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        REF_HOLD             = 3'd0,
        REF_NO_FEATURE       = 3'd1,
        REF_NOT_NEEDED       = 3'd2,
        REF_ORIGIN_MOVED     = 3'd3,
        REF_LARGER           = 3'd4,
        REF_TOO_SMALL        = 3'd5,
        REF_RATIO_MOVED      = 3'd6,
        REF_OUTPUT_TOO_SMALL = 3'd7
    } refusal_t;

    typedef struct packed {
        dim_t                          live_render_w;
        dim_t                          live_render_h;
        dim_t                          live_output_w;
        dim_t                          live_output_h;
        dim_t                          want_render_w;
        dim_t                          want_render_h;
        dim_t                          want_output_w;
        dim_t                          want_output_h;
        logic signed [ORIGIN_BITS-1:0] origin_x;
        logic signed [ORIGIN_BITS-1:0] origin_y;
        dim_t                          texture_w;
        dim_t                          texture_h;
    } item_t;

    typedef struct packed {
        refusal_t refusal;
    } result_t;

    // Outcome of the cheap checks, resolved alongside the products.
    typedef struct packed {
        logic empty;
        logic same;
        logic moved;
        logic grow;
        logic tex_small;
    } early_t;

    typedef struct packed {
        frac_prod_t frac_w;
        frac_prod_t frac_h;
        prod_t      pred_w;
        prod_t      act_w;
        prod_t      pred_h;
        prod_t      act_h;
        tol_prod_t  tolr_w;
        tol_prod_t  tolr_h;
        dim_t       want_rw;
        dim_t       want_rh;
    } prod_set_t;

    typedef struct packed {
        logic in_vld;
        logic prod_vld;
    } pipe_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/lhc_if.sv
// Interfaces: item, result and configuration write channels.
`default_nettype none
interface lhc_item_if;
    logic           valid;
    logic           ready;
    lhc_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lhc_result_if;
    logic             valid;
    logic             ready;
    lhc_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lhc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lhc_pkg::CFG_IDX_W-1:0]      index;
    logic [lhc_pkg::CFG_DATA_W-1:0]     wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lhc_cfg_regs.sv
// Configuration registers: minimum render fraction and ratio tolerance.
`default_nettype none
module lhc_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lhc_cfg_if.sink            cfg,
    output lhc_pkg::minf_t     min_fraction,
    output lhc_pkg::tol_t      ratio_tolerance
);

    lhc_pkg::minf_t min_fraction_reg;
    lhc_pkg::tol_t  ratio_tolerance_reg;

    assign cfg.ready       = 1'b1;
    assign min_fraction    = min_fraction_reg;
    assign ratio_tolerance = ratio_tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_fraction_reg    <= lhc_pkg::minf_t'(32768);
            ratio_tolerance_reg <= lhc_pkg::tol_t'(1);
        end
        else if (cfg.valid)
        begin
            case (lhc_pkg::cfg_reg_t'(cfg.index))
                lhc_pkg::REG_MIN_FRACTION:
                    min_fraction_reg <= cfg.wdata[lhc_pkg::MINF_W-1:0];
                lhc_pkg::REG_RATIO_TOLERANCE:
                    ratio_tolerance_reg <= cfg.wdata[lhc_pkg::TOL_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/lhc_prod_stage.sv
// Input register, then the registered products and the cheap early checks.
`default_nettype none
module lhc_prod_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    lhc_item_if.sink                item,
    input  wire lhc_pkg::minf_t     min_fraction,
    input  wire lhc_pkg::tol_t      ratio_tolerance,
    input  wire logic               down_ready,
    output logic                    prod_valid,
    output lhc_pkg::prod_set_t      prod,
    output lhc_pkg::early_t         early,
    output lhc_pkg::pipe_stat_t     stat
);

    logic                in_vld_reg;
    lhc_pkg::item_t      in_item_reg;
    logic                prod_vld_reg;
    lhc_pkg::prod_set_t  prod_reg;
    lhc_pkg::early_t     early_reg;
    lhc_pkg::prod_set_t  prod_next;
    lhc_pkg::early_t     early_next;
    logic                prod_adv;
    logic                in_adv;

    assign prod_adv   = !prod_vld_reg || down_ready;
    assign in_adv     = !in_vld_reg || prod_adv;
    assign item.ready = in_adv;

    assign prod_valid    = prod_vld_reg;
    assign prod          = prod_reg;
    assign early         = early_reg;
    assign stat.in_vld   = in_vld_reg;
    assign stat.prod_vld = prod_vld_reg;

    always_comb
    begin
        lhc_pkg::item_t a;
        a = in_item_reg;

        early_next.empty = (a.live_render_w == '0) || (a.live_render_h == '0) ||
                           (a.live_output_w == '0) || (a.live_output_h == '0) ||
                           (a.want_render_w == '0) || (a.want_render_h == '0) ||
                           (a.want_output_w == '0) || (a.want_output_h == '0);
        early_next.same  = (a.live_render_w == a.want_render_w) &&
                           (a.live_render_h == a.want_render_h) &&
                           (a.live_output_w == a.want_output_w) &&
                           (a.live_output_h == a.want_output_h);
        early_next.moved = (a.origin_x != '0) || (a.origin_y != '0);
        early_next.grow  = (a.want_render_w > a.live_render_w) ||
                           (a.want_render_h > a.live_render_h) ||
                           (a.want_output_w > a.live_output_w) ||
                           (a.want_output_h > a.live_output_h);
        early_next.tex_small = (a.texture_w == '0) || (a.texture_h == '0) ||
                               (a.texture_w < a.live_output_w) ||
                               (a.texture_h < a.live_output_h);

        prod_next.frac_w  = lhc_pkg::frac_prod_t'(a.live_render_w) *
                            lhc_pkg::frac_prod_t'(min_fraction);
        prod_next.frac_h  = lhc_pkg::frac_prod_t'(a.live_render_h) *
                            lhc_pkg::frac_prod_t'(min_fraction);
        prod_next.pred_w  = lhc_pkg::prod_t'(a.want_render_w) *
                            lhc_pkg::prod_t'(a.live_output_w);
        prod_next.act_w   = lhc_pkg::prod_t'(a.want_output_w) *
                            lhc_pkg::prod_t'(a.live_render_w);
        prod_next.pred_h  = lhc_pkg::prod_t'(a.want_render_h) *
                            lhc_pkg::prod_t'(a.live_output_h);
        prod_next.act_h   = lhc_pkg::prod_t'(a.want_output_h) *
                            lhc_pkg::prod_t'(a.live_render_h);
        prod_next.tolr_w  = lhc_pkg::tol_prod_t'(ratio_tolerance) *
                            lhc_pkg::tol_prod_t'(a.live_render_w);
        prod_next.tolr_h  = lhc_pkg::tol_prod_t'(ratio_tolerance) *
                            lhc_pkg::tol_prod_t'(a.live_render_h);
        prod_next.want_rw = a.want_render_w;
        prod_next.want_rh = a.want_render_h;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_vld_reg <= item.valid;
            end
            if (prod_adv)
            begin
                prod_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && item.valid)
        begin
            in_item_reg <= item.data;
        end
        if (prod_adv && in_vld_reg)
        begin
            prod_reg  <= prod_next;
            early_reg <= early_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/lhc_decide_stage.sv
// Final compares, priority selection of the refusal code and the result register.
`default_nettype none
module lhc_decide_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               prod_valid,
    input  wire lhc_pkg::prod_set_t prod,
    input  wire lhc_pkg::early_t    early,
    output logic                    prod_ready,
    lhc_result_if.source            result
);

    logic                 out_vld_reg;
    lhc_pkg::refusal_t    refusal_reg;
    lhc_pkg::refusal_t    refusal_next;
    lhc_pkg::frac_prod_t  scaled_w;
    lhc_pkg::frac_prod_t  scaled_h;
    lhc_pkg::prod_t       diff_w;
    lhc_pkg::prod_t       diff_h;
    logic                 below_fraction;
    logic                 scale_skewed;
    logic                 out_adv;

    assign out_adv    = !out_vld_reg || result.ready;
    assign prod_ready = out_adv;

    // Wanted extent in the fraction's scale, widened to the product width.
    assign scaled_w = lhc_pkg::frac_prod_t'({prod.want_rw, {lhc_pkg::FRACTION_BITS{1'b0}}});
    assign scaled_h = lhc_pkg::frac_prod_t'({prod.want_rh, {lhc_pkg::FRACTION_BITS{1'b0}}});
    assign below_fraction = (scaled_w < prod.frac_w) || (scaled_h < prod.frac_h);

    assign diff_w = (prod.pred_w > prod.act_w) ? prod.pred_w - prod.act_w
                                               : prod.act_w - prod.pred_w;
    assign diff_h = (prod.pred_h > prod.act_h) ? prod.pred_h - prod.act_h
                                               : prod.act_h - prod.pred_h;
    assign scale_skewed = (diff_w > lhc_pkg::prod_t'(prod.tolr_w)) ||
                          (diff_h > lhc_pkg::prod_t'(prod.tolr_h));

    always_comb
    begin
        if (early.empty)
            refusal_next = lhc_pkg::REF_NO_FEATURE;
        else if (early.same)
            refusal_next = lhc_pkg::REF_NOT_NEEDED;
        else if (early.moved)
            refusal_next = lhc_pkg::REF_ORIGIN_MOVED;
        else if (early.grow)
            refusal_next = lhc_pkg::REF_LARGER;
        else if (below_fraction)
            refusal_next = lhc_pkg::REF_TOO_SMALL;
        else if (scale_skewed)
            refusal_next = lhc_pkg::REF_RATIO_MOVED;
        else if (early.tex_small)
            refusal_next = lhc_pkg::REF_OUTPUT_TOO_SMALL;
        else
            refusal_next = lhc_pkg::REF_HOLD;
    end

    assign result.valid        = out_vld_reg;
    assign result.data.refusal = refusal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_vld_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && prod_valid)
        begin
            refusal_reg <= refusal_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/letterbox_hold_check_core.sv
// Top level: letterbox hold check, one refusal code per input beat.
//
//  channel | dir  | beat carries                              | handshake
//  --------+------+-------------------------------------------+-------------
//  item    | in   | live/wanted rects, origin, texture size   | valid/ready
//  result  | out  | refusal code (3 bits)                     | valid/ready
//  cfg     | in   | register index, write data                | valid/ready
//
// Each beat passes an input register, a product register (the eight
// multipliers) and the result register, in that order: one beat per cycle is
// sustained while the result is not stalled. The configuration
// port is always ready. Reset clears the stage valid flags and loads the
// register defaults. A stalled result holds; earlier stages keep filling, and
// input ready drops only once all three stages hold a beat.
`default_nettype none
module letterbox_hold_check_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lhc_item_if.sink      item,
    lhc_result_if.source  result,
    lhc_cfg_if.sink       cfg
);

    lhc_pkg::minf_t       min_fraction;
    lhc_pkg::tol_t        ratio_tolerance;
    logic                 prod_valid;
    logic                 prod_ready;
    lhc_pkg::prod_set_t   prod;
    lhc_pkg::early_t      early;
    lhc_pkg::pipe_stat_t  stat;

    lhc_cfg_regs u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .min_fraction    (min_fraction),
        .ratio_tolerance (ratio_tolerance)
    );

    lhc_prod_stage u_prod (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .min_fraction    (min_fraction),
        .ratio_tolerance (ratio_tolerance),
        .down_ready      (prod_ready),
        .prod_valid      (prod_valid),
        .prod            (prod),
        .early           (early),
        .stat            (stat)
    );

    lhc_decide_stage u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .early      (early),
        .prod_ready (prod_ready),
        .result     (result)
    );

    // Input backpressure only appears once every stage holds a beat.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (stat.in_vld && stat.prod_vld && result.valid))
        else $error("item stalled while the pipeline has a free stage");

    // An empty rect always wins the priority order.
    a_empty_first: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && prod_ready && early.empty)
        |=> (result.valid && result.data.refusal == lhc_pkg::REF_NO_FEATURE))
        else $error("empty rect did not give the no-feature code");

    // A write to the fraction register lands the next cycle.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready &&
         cfg.index == lhc_pkg::CFG_IDX_W'(lhc_pkg::REG_MIN_FRACTION))
        |=> (min_fraction == $past(cfg.wdata[lhc_pkg::MINF_W-1:0])))
        else $error("min_fraction write was not taken");

endmodule
`default_nettype wire

>>> tb/sv/letterbox_hold_check_core_test.sv
// Testbench: random and directed hold checks against a cycle-free predictor, with backpressure.
module letterbox_hold_check_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lhc_pkg::*;

    localparam int          CLK_PERIOD         = 10;
    localparam int          RESET_CYCLES       = 12;
    localparam int          SETTLE_CYCLES      = 8;
    localparam int          TIMEOUT_CYCLES     = 200000;
    localparam int          REPORT_LIMIT       = 10;
    localparam int          PHASE_COUNT        = 7;
    localparam int          RANDOM_PER_PHASE   = 183;
    localparam int          STEADY_PHASE       = 3;
    localparam int          LONG_HOLD_CYCLES   = 80;
    localparam int          LONG_HOLD_FIRST    = 300;
    localparam int          LONG_HOLD_SECOND   = 1000;
    localparam int          MODE_CYCLES        = 64;
    localparam int unsigned MIN_FRACTION_ONE   = 1 << FRACTION_BITS;
    localparam int unsigned MIN_FRACTION_RESET = 32768;
    localparam int unsigned TOLERANCE_RESET    = 1;
    localparam int unsigned DIM_MAX            = (1 << DIM_BITS) - 1;

    logic clk = 1'b0;
    logic rst_n;

    lhc_item_if   item_ch ();
    lhc_result_if result_ch ();
    lhc_cfg_if    cfg_ch ();

    letterbox_hold_check_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor's copy of the configuration registers.
    minf_t min_fraction_now = minf_t'(MIN_FRACTION_RESET);
    tol_t  tolerance_now    = tol_t'(TOLERANCE_RESET);

    item_t    pending_items[$];
    refusal_t expected_refusals[$];
    int       queued_items   = 0;
    int       accepted_items = 0;
    int       error_count    = 0;
    bit       steady_phase   = 1'b0;

    // Sender state.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver state.
    int       results_seen = 0;
    int       hold_left    = 0;
    int       mode_cycles  = 0;
    int       ready_mode   = 0;
    refusal_t oldest_refusal;

    function automatic refusal_t predict_refusal(item_t it, minf_t mf, tol_t tol);
        longint unsigned lrw, lrh, low, loh, wrw, wrh, wow, woh, frac, tolv;
        longint unsigned pred_w, act_w, pred_h, act_h, diff_w, diff_h;
        lrw  = 64'(it.live_render_w);
        lrh  = 64'(it.live_render_h);
        low  = 64'(it.live_output_w);
        loh  = 64'(it.live_output_h);
        wrw  = 64'(it.want_render_w);
        wrh  = 64'(it.want_render_h);
        wow  = 64'(it.want_output_w);
        woh  = 64'(it.want_output_h);
        frac = 64'(mf);
        tolv = 64'(tol);
        if (lrw == 0 || lrh == 0 || low == 0 || loh == 0)
            return REF_NO_FEATURE;
        if (wrw == 0 || wrh == 0 || wow == 0 || woh == 0)
            return REF_NO_FEATURE;
        if (lrw == wrw && lrh == wrh && low == wow && loh == woh)
            return REF_NOT_NEEDED;
        if (it.origin_x != '0 || it.origin_y != '0)
            return REF_ORIGIN_MOVED;
        if (wrw > lrw || wrh > lrh || wow > low || woh > loh)
            return REF_LARGER;
        if ((wrw << FRACTION_BITS) < lrw * frac || (wrh << FRACTION_BITS) < lrh * frac)
            return REF_TOO_SMALL;
        // Cross products compare the render/output scale of both rects.
        pred_w = wrw * low;
        act_w  = wow * lrw;
        pred_h = wrh * loh;
        act_h  = woh * lrh;
        diff_w = (pred_w > act_w) ? pred_w - act_w : act_w - pred_w;
        diff_h = (pred_h > act_h) ? pred_h - act_h : act_h - pred_h;
        if (diff_w > tolv * lrw || diff_h > tolv * lrh)
            return REF_RATIO_MOVED;
        if (it.texture_w == '0 || it.texture_h == '0 || it.texture_w < it.live_output_w ||
            it.texture_h < it.live_output_h)
            return REF_OUTPUT_TOO_SMALL;
        return REF_HOLD;
    endfunction

    // Extent with a random magnitude, so that small and large sizes both appear.
    function automatic dim_t random_extent();
        int unsigned nb;
        nb = $urandom_range(1, DIM_BITS);
        return dim_t'($urandom_range(1, (1 << nb) - 1));
    endfunction

    function automatic item_t random_item();
        item_t        it;
        int unsigned  pick;
        longint       lrw, lrh, low, loh, wrw, wrh, wow, woh, scale;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return it;
        end
        lrw = longint'(random_extent());
        lrh = longint'(random_extent());
        low = longint'(random_extent());
        loh = longint'(random_extent());
        scale = longint'($urandom_range(16384, MIN_FRACTION_ONE));
        wrw = (lrw * scale) >> FRACTION_BITS;
        if ($urandom_range(0, 1) == 0)
            scale = longint'($urandom_range(16384, MIN_FRACTION_ONE));
        wrh = (lrh * scale) >> FRACTION_BITS;
        if (wrw < 1)
            wrw = 1;
        if (wrh < 1)
            wrh = 1;
        // Wanted output follows the render scale, jittered around the tolerance edge.
        wow = (wrw * low) / lrw + longint'($urandom_range(0, 4)) - 2;
        woh = (wrh * loh) / lrh + longint'($urandom_range(0, 4)) - 2;
        if (wow < 1)
            wow = 1;
        if (wow > low)
            wow = low;
        if (woh < 1)
            woh = 1;
        if (woh > loh)
            woh = loh;
        if (pick < 12)
        begin
            wrw = lrw;
            wrh = lrh;
            wow = low;
            woh = loh;
        end
        else if (pick < 16)
        begin
            case ($urandom_range(0, 7))
                0: lrw = 0;
                1: lrh = 0;
                2: low = 0;
                3: loh = 0;
                4: wrw = 0;
                5: wrh = 0;
                6: wow = 0;
                default: woh = 0;
            endcase
        end
        else if (pick < 22)
        begin
            case ($urandom_range(0, 3))
                0: wrw = lrw + 1;
                1: wrh = lrh + 1;
                2: wow = low + 1;
                default: woh = loh + 1;
            endcase
        end
        it.live_render_w = dim_t'(lrw);
        it.live_render_h = dim_t'(lrh);
        it.live_output_w = dim_t'(low);
        it.live_output_h = dim_t'(loh);
        it.want_render_w = dim_t'(wrw);
        it.want_render_h = dim_t'(wrh);
        it.want_output_w = dim_t'(wow);
        it.want_output_h = dim_t'(woh);
        it.origin_x = ($urandom_range(0, 15) == 0) ? ORIGIN_BITS'($urandom) : '0;
        it.origin_y = ($urandom_range(0, 15) == 0) ? ORIGIN_BITS'($urandom) : '0;
        if ($urandom_range(0, 99) < 85)
        begin
            it.texture_w = ($urandom_range(0, 3) == 0) ? it.live_output_w :
                dim_t'($urandom_range(it.live_output_w, DIM_MAX));
            it.texture_h = ($urandom_range(0, 3) == 0) ? it.live_output_h :
                dim_t'($urandom_range(it.live_output_h, DIM_MAX));
        end
        else
        begin
            it.texture_w = ($urandom_range(0, 2) == 0) ? '0 : random_extent();
            it.texture_h = ($urandom_range(0, 2) == 0) ? '0 : random_extent();
        end
        return it;
    endfunction

    task automatic queue_item(input item_t it);
        pending_items.push_back(it);
        queued_items++;
    endtask

    task automatic wait_drained();
        while (accepted_items != queued_items || expected_refusals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_MIN_FRACTION)
            min_fraction_now = value[MINF_W-1:0];
        else
            tolerance_now = value[TOL_W-1:0];
    endtask

    // Sender: bursts of beats with random gaps, fed from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_refusals.push_back(
                    predict_refusal(item_ch.data, min_fraction_now, tolerance_now));
                accepted_items++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item_ch.valid <= 1'b1;
                    item_ch.data  <= pending_items.pop_front();
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = int'($urandom_range(1, 24));
                        gap_left   = steady_phase ? 0 : int'($urandom_range(0, 7));
                    end
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and stalls on a changing pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (results_seen == LONG_HOLD_FIRST || results_seen == LONG_HOLD_SECOND)
                    hold_left = LONG_HOLD_CYCLES;
                if (expected_refusals.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected result beat: refusal %0d", result_ch.data.refusal);
                end
                else
                begin
                    oldest_refusal = expected_refusals.pop_front();
                    if (result_ch.data.refusal !== oldest_refusal)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("result %0d refusal: expected %s (%0d), got %0d",
                                     results_seen, oldest_refusal.name(), oldest_refusal,
                                     result_ch.data.refusal);
                    end
                end
            end
            mode_cycles++;
            if (mode_cycles >= MODE_CYCLES)
            begin
                mode_cycles = 0;
                ready_mode  = int'($urandom_range(0, 3));
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (steady_phase)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                case (ready_mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= mode_cycles[2];
                endcase
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("letterbox_hold_check_core_test: errors");
        $finish;
    end

    initial
    begin
        item_t base;
        item_t probe;
        logic [CFG_DATA_W-1:0] minf_value;
        logic [CFG_DATA_W-1:0] tol_value;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_MIN_FRACTION;
        cfg_ch.wdata <= '0;
        rst_n <= 1'b0;

        // A rect that passes every check under the reset configuration.
        base = '0;
        base.live_render_w = 16'd100;
        base.live_render_h = 16'd80;
        base.live_output_w = 16'd200;
        base.live_output_h = 16'd160;
        base.want_render_w = 16'd80;
        base.want_render_h = 16'd64;
        base.want_output_w = 16'd160;
        base.want_output_h = 16'd128;
        base.texture_w     = 16'd200;
        base.texture_h     = 16'd160;
        queue_item(base);
        probe = base; probe.live_render_w = '0; queue_item(probe);
        probe = base; probe.want_output_h = '0; queue_item(probe);
        queue_item('0);
        // Same rect wins over a moved origin.
        probe = base;
        probe.want_render_w = 16'd100; probe.want_render_h = 16'd80;
        probe.want_output_w = 16'd200; probe.want_output_h = 16'd160;
        probe.origin_x = 16'sd5;
        queue_item(probe);
        probe = base; probe.origin_x = 16'sh8000; queue_item(probe);
        probe = base; probe.origin_y = 16'sh7fff; queue_item(probe);
        probe = base; probe.origin_x = -16'sd1; probe.origin_y = 16'sd1; queue_item(probe);
        probe = base; probe.want_render_w = 16'd101; queue_item(probe);
        probe = base; probe.want_output_h = 16'd161; queue_item(probe);
        probe = base; probe.want_render_w = 16'd49; queue_item(probe);
        // Exactly at the minimum fraction: passes that check, then fails on ratio.
        probe = base; probe.want_render_w = 16'd50; queue_item(probe);
        probe = base; probe.want_output_w = 16'd159; queue_item(probe);
        probe = base; probe.want_output_w = 16'd158; queue_item(probe);
        probe = base; probe.texture_w = '0; queue_item(probe);
        probe = base; probe.texture_h = 16'd159; queue_item(probe);
        probe = base; probe.texture_w = '1; probe.texture_h = '1; queue_item(probe);
        probe = '0;
        probe.live_render_w = '1; probe.live_render_h = '1;
        probe.live_output_w = '1; probe.live_output_h = '1;
        probe.want_render_w = dim_t'(DIM_MAX - 1); probe.want_render_h = dim_t'(DIM_MAX - 1);
        probe.want_output_w = dim_t'(DIM_MAX - 1); probe.want_output_h = dim_t'(DIM_MAX - 1);
        probe.texture_w = '1; probe.texture_h = '1;
        queue_item(probe);
        probe = '1; queue_item(probe);
        probe = '0;
        probe.live_render_w = '1; probe.live_render_h = '1;
        probe.live_output_w = '1; probe.live_output_h = '1;
        probe.want_render_w = 16'd1; probe.want_render_h = 16'd1;
        probe.want_output_w = 16'd1; probe.want_output_h = 16'd1;
        probe.texture_w = '1; probe.texture_h = '1;
        queue_item(probe);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase != 0)
            begin
                wait_drained();
                case (phase)
                    1:
                    begin
                        minf_value = '0;
                        tol_value  = '0;
                    end
                    2:
                    begin
                        minf_value = CFG_DATA_W'(MIN_FRACTION_ONE);
                        tol_value  = CFG_DATA_W'(255);
                    end
                    3:
                    begin
                        minf_value = CFG_DATA_W'(MIN_FRACTION_ONE - 1);
                        tol_value  = CFG_DATA_W'(1);
                    end
                    4:
                    begin
                        minf_value = CFG_DATA_W'(MIN_FRACTION_RESET);
                        tol_value  = CFG_DATA_W'(TOLERANCE_RESET);
                    end
                    default:
                    begin
                        minf_value = CFG_DATA_W'($urandom_range(0, MIN_FRACTION_ONE));
                        tol_value  = CFG_DATA_W'($urandom_range(0, 255));
                    end
                endcase
                // Bits above the tolerance width are ignored by the register.
                if (phase >= 5)
                    tol_value[CFG_DATA_W-1:TOL_W] = (CFG_DATA_W - TOL_W)'($urandom);
                write_register(REG_MIN_FRACTION, minf_value);
                write_register(REG_RATIO_TOLERANCE, tol_value);
                steady_phase = (phase == STEADY_PHASE);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                queue_item(random_item());
        end

        wait_drained();
        if (expected_refusals.size() != 0)
        begin
            error_count += expected_refusals.size();
            $display("%0d result beats never arrived", expected_refusals.size());
        end
        if (error_count == 0)
            $display("letterbox_hold_check_core_test: clean");
        else
            $display("letterbox_hold_check_core_test: errors");
        $finish;
    end

endmodule
